// ===== rtl/core/wste_pkg.sv =====
package wste_pkg;

    localparam int CMD_W     = 4;
    localparam int VALUE_W   = 32;
    localparam int IDX_W     = 6;
    localparam int DATA_W    = 32;
    localparam int COUNT_W   = 7;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 40;

    localparam int S_CMD_LSB   = 0;
    localparam int S_VALUE_LSB = S_CMD_LSB + CMD_W;
    localparam int S_IDX_LSB   = S_VALUE_LSB + VALUE_W;

    localparam int M_DATA_LSB  = 0;
    localparam int M_OK_BIT    = M_DATA_LSB + DATA_W;
    localparam int M_COUNT_LSB = M_OK_BIT + 1;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD        = 4'd0,
        CMD_TAKE_FIRST = 4'd1,
        CMD_CONTAINS   = 4'd2,
        CMD_REMOVE     = 4'd3,
        CMD_READ_AT    = 4'd4,
        CMD_WRITE_AT   = 4'd5,
        CMD_REMOVE_AT  = 4'd6,
        CMD_SORT       = 4'd7,
        CMD_TAKE_LAST  = 4'd8
    } t_cmd;

endpackage

// ===== rtl/core/word_set_table_engine.sv =====
// Unordered word set, duplicates allowed, held in one synchronous RAM of
// CAPACITY words (one write port, one read port, registered read data).
// Input channel (i_s_*): one transaction per command: cmd, value, index.
// Output channel (o_m_*): exactly one transaction per command: data, ok and
// the count held after the command, in command order.
// Commands run one at a time; the input is ready whenever the engine is idle,
// also while a result still sits unread in the output register. The next
// input transaction can be taken in the cycle after a result enters that register.
// add, write_at, an unknown command and any failed or empty-set command go
// straight to the result; read_at, take_first, take_last and remove_at read
// the RAM first; contains and remove scan the held words in order until the
// first match. Sort is an in-place selection sort that reads one RAM word per
// cycle while it scans a row, as the single RAM read port allows.
// Reset clears the count, the engine state and the output valid; RAM contents
// are left as they are, and only positions below the count are ever read.
// A stalled output holds its result; the next command may already run and
// then waits in its final state until the output register frees up.
module word_set_table_engine #(
    parameter int CAPACITY  = 64,
    parameter int WORD_BITS = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // [3:0] cmd, [35:4] value, [41:36] index, [47:42] zero
    input  logic [wste_pkg::S_TDATA_W-1:0]   i_s_tdata,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // [31:0] data, [32] ok, [39:33] count
    output logic [wste_pkg::M_TDATA_W-1:0]   o_m_tdata
);
    import wste_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > IDX_W) ? CW : IDX_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DROP1,
        S_DROP2,
        S_SCAN,
        S_SORT,
        S_EMIT
    } t_state;

    t_state                 r_state, n_state;
    t_cmd                   r_cmd, n_cmd;
    logic [WORD_BITS-1:0]   r_val, n_val;
    logic [AW-1:0]          r_pos, n_pos;
    logic [CW-1:0]          r_ptr, n_ptr;
    logic [AW-1:0]          r_i, n_i;
    logic [WORD_BITS-1:0]   r_cur, n_cur;
    logic                   r_dv, n_dv;
    logic [AW-1:0]          r_tag, n_tag;
    logic [CW-1:0]          r_fill, n_fill;
    logic [DATA_W-1:0]      r_taken, n_taken;
    logic [DATA_W-1:0]      r_res_data, n_res_data;
    logic                   r_res_ok, n_res_ok;
    logic                   r_m_valid, n_m_valid;
    logic [DATA_W-1:0]      r_m_data, n_m_data;
    logic                   r_m_ok, n_m_ok;
    logic [COUNT_W-1:0]     r_m_count, n_m_count;

    logic [WORD_BITS-1:0]   r_mem [CAPACITY];
    logic [WORD_BITS-1:0]   r_rd_data;
    logic                   rd_en, wr_en;
    logic [AW-1:0]          rd_addr, wr_addr;
    logic [WORD_BITS-1:0]   wr_data;

    logic                   accept;
    t_cmd                   in_cmd;
    logic [WORD_BITS-1:0]   in_val;
    logic [IDX_W-1:0]       in_idx;
    logic                   idx_ok;
    logic [AW-1:0]          last_addr;
    logic [AW-1:0]          ptr_addr;

    assign o_s_tready = (r_state == S_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign in_cmd     = t_cmd'(i_s_tdata[S_CMD_LSB +: CMD_W]);
    assign in_val     = WORD_BITS'(i_s_tdata[S_VALUE_LSB +: VALUE_W]);
    assign in_idx     = i_s_tdata[S_IDX_LSB +: IDX_W];
    assign idx_ok     = (XW'(in_idx) < XW'(r_fill));
    assign last_addr  = AW'(r_fill - 1'b1);
    assign ptr_addr   = AW'(r_ptr);

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {r_m_count, r_m_ok, r_m_data};

    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_val      = r_val;
        n_pos      = r_pos;
        n_ptr      = r_ptr;
        n_i        = r_i;
        n_cur      = r_cur;
        n_dv       = 1'b0;
        n_tag      = r_tag;
        n_fill     = r_fill;
        n_taken    = r_taken;
        n_res_data = r_res_data;
        n_res_ok   = r_res_ok;
        n_m_valid  = r_m_valid && !i_m_tready;
        n_m_data   = r_m_data;
        n_m_ok     = r_m_ok;
        n_m_count  = r_m_count;
        rd_en      = 1'b0;
        rd_addr    = '0;
        wr_en      = 1'b0;
        wr_addr    = '0;
        wr_data    = r_cur;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_cmd      = in_cmd;
                    n_val      = in_val;
                    n_res_data = '0;
                    n_res_ok   = 1'b0;
                    n_state    = S_EMIT;
                    case (in_cmd)
                        CMD_ADD: begin
                            if (r_fill < CW'(CAPACITY)) begin
                                wr_en    = 1'b1;
                                wr_addr  = AW'(r_fill);
                                wr_data  = in_val;
                                n_fill   = r_fill + 1'b1;
                                n_res_ok = 1'b1;
                            end
                        end
                        CMD_TAKE_FIRST: begin
                            if (r_fill != '0) begin
                                rd_en   = 1'b1;
                                rd_addr = '0;
                                n_pos   = '0;
                                n_state = S_DROP1;
                            end
                        end
                        CMD_TAKE_LAST: begin
                            if (r_fill != '0) begin
                                rd_en   = 1'b1;
                                rd_addr = last_addr;
                                n_pos   = last_addr;
                                n_state = S_DROP1;
                            end
                        end
                        CMD_READ_AT, CMD_REMOVE_AT: begin
                            if (idx_ok) begin
                                rd_en   = 1'b1;
                                rd_addr = AW'(in_idx);
                                n_pos   = AW'(in_idx);
                                n_state = S_DROP1;
                            end
                        end
                        CMD_WRITE_AT: begin
                            if (idx_ok) begin
                                wr_en    = 1'b1;
                                wr_addr  = AW'(in_idx);
                                wr_data  = in_val;
                                n_res_ok = 1'b1;
                            end
                        end
                        CMD_CONTAINS, CMD_REMOVE: begin
                            if (r_fill != '0) begin
                                n_ptr   = '0;
                                n_state = S_SCAN;
                            end
                        end
                        CMD_SORT: begin
                            n_res_ok = 1'b1;
                            if (r_fill != '0) begin
                                n_i     = '0;
                                n_ptr   = '0;
                                n_state = S_SORT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_DROP1: begin
                n_taken = DATA_W'(r_rd_data);
                if (r_cmd == CMD_READ_AT) begin
                    n_res_data = DATA_W'(r_rd_data);
                    n_res_ok   = 1'b1;
                    n_state    = S_EMIT;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = last_addr;
                    n_state = S_DROP2;
                end
            end

            S_DROP2: begin
                // hole at r_pos takes the last word
                wr_en      = 1'b1;
                wr_addr    = r_pos;
                wr_data    = r_rd_data;
                n_fill     = r_fill - 1'b1;
                n_res_ok   = 1'b1;
                n_res_data = (r_cmd == CMD_REMOVE) ? '0 : r_taken;
                n_state    = S_EMIT;
            end

            S_SCAN: begin
                if (r_dv && (r_rd_data == r_val)) begin
                    if (r_cmd == CMD_REMOVE) begin
                        n_pos   = r_tag;
                        n_state = S_DROP1;
                    end else begin
                        n_res_ok = 1'b1;
                        n_state  = S_EMIT;
                    end
                end else if (!r_dv && (r_ptr == r_fill)) begin
                    n_state = S_EMIT;
                end else if (r_ptr < r_fill) begin
                    rd_en   = 1'b1;
                    rd_addr = ptr_addr;
                    n_ptr   = r_ptr + 1'b1;
                    n_dv    = 1'b1;
                    n_tag   = ptr_addr;
                end
            end

            S_SORT: begin
                if (r_dv) begin
                    if (r_tag == r_i) begin
                        n_cur = r_rd_data;
                    end else if (r_rd_data < r_cur) begin
                        wr_en   = 1'b1;
                        wr_addr = r_tag;
                        wr_data = r_cur;
                        n_cur   = r_rd_data;
                    end
                end
                if (r_ptr < r_fill) begin
                    rd_en   = 1'b1;
                    rd_addr = ptr_addr;
                    n_ptr   = r_ptr + 1'b1;
                    n_dv    = 1'b1;
                    n_tag   = ptr_addr;
                end else if (!r_dv) begin
                    // row done: minimum goes to slot r_i
                    wr_en   = 1'b1;
                    wr_addr = r_i;
                    wr_data = r_cur;
                    if (CW'(r_i) == r_fill - 1'b1) begin
                        n_state = S_EMIT;
                    end else begin
                        n_i   = r_i + 1'b1;
                        n_ptr = CW'(r_i) + 1'b1;
                    end
                end
            end

            S_EMIT: begin
                if (!r_m_valid || i_m_tready) begin
                    n_m_valid = 1'b1;
                    n_m_data  = r_res_data;
                    n_m_ok    = r_res_ok;
                    n_m_count = COUNT_W'(r_fill);
                    n_state   = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_fill    <= '0;
            r_dv      <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_fill    <= n_fill;
            r_dv      <= n_dv;
            r_m_valid <= n_m_valid;
        end
        r_cmd      <= n_cmd;
        r_val      <= n_val;
        r_pos      <= n_pos;
        r_ptr      <= n_ptr;
        r_i        <= n_i;
        r_cur      <= n_cur;
        r_tag      <= n_tag;
        r_taken    <= n_taken;
        r_res_data <= n_res_data;
        r_res_ok   <= n_res_ok;
        r_m_data   <= n_m_data;
        r_m_ok     <= n_m_ok;
        r_m_count  <= n_m_count;
    end

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(CAPACITY))
        else $error("fill above capacity");

    a_emit_no_ram: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (!wr_en && !rd_en))
        else $error("RAM access while emitting result");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state != S_IDLE))
        else $error("accepted transaction left engine idle");

    a_fill_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> ((r_fill == $past(r_fill)) ||
                            (r_fill == $past(r_fill) + 1'b1) ||
                            (r_fill == $past(r_fill) - 1'b1)))
        else $error("fill moved by more than one");

    a_scan_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> ((r_cmd == CMD_CONTAINS) || (r_cmd == CMD_REMOVE)))
        else $error("value scan for wrong command");
`endif

endmodule
